[hw/rtl/assert_macros.svh]
// assertion helpers for the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at each posedge outside reset
`define LBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at each posedge, reset included
`define LBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lbs_pkg.sv]
package lbs_pkg;

   localparam int unsigned CUR_W   = 16;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned GAMMA_W = 17;
   localparam int unsigned GAMMA_FRAC_W = 16;

   typedef enum logic [2:0] {
      PH_RAMP_UP    = 3'd0,
      PH_HOLD_HIGH  = 3'd1,
      PH_LV_WAIT    = 3'd2,
      PH_FORCED_OFF = 3'd3,
      PH_RAMP_DOWN  = 3'd4,
      PH_HOLD_LOW   = 3'd5
   } phase_type;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_HOLD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_HOLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ON       = 3'd4;

   localparam logic [CSR_W-1:0] RST_CURRENT_LOW  = 16'd0;
   localparam logic [CSR_W-1:0] RST_CURRENT_HIGH = 16'd1000;
   localparam logic [CSR_W-1:0] RST_HIGH_HOLD    = 16'd64;
   localparam logic [CSR_W-1:0] RST_LOW_HOLD     = 16'd64;
   localparam logic [CSR_W-1:0] RST_MIN_ON       = 16'd0;

   // largest g with g^10 * steps^tenths <= level^tenths * 2^160, evaluated at elaboration
   function automatic logic [GAMMA_W-1:0] lbs_gamma_entry(input int unsigned level,
                                                          input int unsigned steps,
                                                          input int unsigned tenths);
      logic [511:0] steps_pow;
      logic [511:0] rhs;
      logic [511:0] lhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      int           k;
      int           it;
      steps_pow = 512'd1;
      rhs       = 512'd1;
      for (k = 0; k < int'(tenths); k++) begin
         steps_pow = steps_pow * 512'(steps);
         rhs       = rhs * 512'(level);
      end
      rhs = rhs << 160;
      lo  = 0;
      hi  = 65536;
      for (it = 0; it < 20; it++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            lhs = steps_pow;
            for (k = 0; k < 10; k++) begin
               lhs = lhs * 512'(mid);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return GAMMA_W'(lo);
   endfunction

endpackage

[hw/rtl/lbs_level_current.sv]
module lbs_level_current
   import lbs_pkg::*;
#(
   parameter int unsigned STEPS        = 64,
   parameter int unsigned GAMMA_TENTHS = 22,
   localparam int unsigned LevelW      = $clog2(STEPS + 1)
) (
   input  logic [LevelW-1:0] level,
   input  logic [CUR_W-1:0]  current_low,
   input  logic [CUR_W-1:0]  current_high,
   output logic [CUR_W-1:0]  current
);

   localparam int unsigned ProdW = CUR_W + GAMMA_W + 2;

   logic [GAMMA_W-1:0]               gamma_rom [0:STEPS];
   logic [GAMMA_W-1:0]               gamma;
   logic signed [CUR_W:0]            diff;
   logic signed [CUR_W+GAMMA_W+1:0]  prod;
   logic signed [CUR_W+GAMMA_W+1:0]  scaled;

   // gamma curve in q1.16, fixed at build time
   for (genvar l = 0; l <= STEPS; l++) begin : g_rom
      localparam logic [GAMMA_W-1:0] Entry = lbs_gamma_entry(l, STEPS, GAMMA_TENTHS);
      assign gamma_rom[l] = Entry;
   end

   assign gamma  = gamma_rom[level];
   assign diff   = signed'({1'b0, current_high}) - signed'({1'b0, current_low});
   assign prod   = ProdW'(diff) * ProdW'(signed'({1'b0, gamma}));
   // arithmetic shift floors towards minus infinity
   assign scaled = prod >>> GAMMA_FRAC_W;
   assign current = current_low + scaled[CUR_W-1:0];

endmodule

[hw/rtl/led_breathing_sequencer.sv]
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_command, req_low_voltage_alert
// rsp      out        rsp_valid/rsp_stall  rsp_drive_current_ma, rsp_led_on, rsp_phase
// csr      in         csr_write_en         csr_index, csr_write_data
//
// one result per transaction, rsp_valid rises once it has moved from the input register to the result register
// a new transaction is taken every cycle while no held result stalls the input; the gamma rom, one subtract,
// one 17x18 multiply and one add sit between the input register and the result register
// synchronous active-high reset empties both stages, zeroes the sequencer state
// and loads the register defaults
// a held result keeps one further transaction waiting in the input register
module led_breathing_sequencer
   import lbs_pkg::*;
#(
   parameter int unsigned STEPS        = 64,
   parameter int unsigned GAMMA_TENTHS = 22
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic                 req_low_voltage_alert,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CUR_W-1:0]     rsp_drive_current_ma,
   output logic                 rsp_led_on,
   output logic [2:0]           rsp_phase,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

`include "assert_macros.svh"

   localparam int unsigned LevelW = $clog2(STEPS + 1);
   localparam logic [LevelW-1:0] LevelTop    = LevelW'(STEPS);
   localparam logic [CUR_W-1:0]  WaitTicks   = CUR_W'(STEPS);
   localparam logic [CUR_W-1:0]  OffTicks    = CUR_W'(STEPS / 3);

   logic [CSR_W-1:0]  current_low_ff, current_high_ff, high_hold_ff, low_hold_ff, min_on_ff;

   logic              in_valid_ff, in_valid_in;
   logic              in_command_ff;
   logic              in_alert_ff;

   phase_type         phase_ff, phase_in;
   logic [LevelW-1:0] level_ff, level_in;
   logic [CUR_W-1:0]  count_ff, count_in;
   logic [CUR_W-1:0]  current_ff, current_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CUR_W-1:0]  rsp_current_ff;
   logic              rsp_led_ff, led_in;
   phase_type         rsp_phase_ff;

   logic              advance;
   logic              fire;
   logic              accept;
   logic              forced_off;
   logic              load_current;
   logic [CUR_W-1:0]  level_current;

   logic                         top_phase;
   logic                         rsp_forced_off;
   logic [LevelW+2*CUR_W+2:0]    state_vec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_low_ff  <= RST_CURRENT_LOW;
         current_high_ff <= RST_CURRENT_HIGH;
         high_hold_ff    <= RST_HIGH_HOLD;
         low_hold_ff     <= RST_LOW_HOLD;
         min_on_ff       <= RST_MIN_ON;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CURRENT_LOW:  current_low_ff  <= csr_write_data;
            CSR_CURRENT_HIGH: current_high_ff <= csr_write_data;
            CSR_HIGH_HOLD:    high_hold_ff    <= csr_write_data;
            CSR_LOW_HOLD:     low_hold_ff     <= csr_write_data;
            CSR_MIN_ON:       min_on_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_command_ff <= req_command;
         in_alert_ff   <= req_low_voltage_alert;
      end
   end

   lbs_level_current #(
      .STEPS        (STEPS),
      .GAMMA_TENTHS (GAMMA_TENTHS)
   ) u_level_current (
      .level        (level_in),
      .current_low  (current_low_ff),
      .current_high (current_high_ff),
      .current      (level_current)
   );

   // sequencer step for the transaction in the input register
   always_comb begin
      phase_in     = phase_ff;
      level_in     = level_ff;
      count_in     = count_ff;
      forced_off   = 1'b0;
      load_current = 1'b0;
      if (in_command_ff == CMD_RESTART) begin
         phase_in = PH_RAMP_UP;
         count_in = '0;
      end else begin
         unique case (phase_ff)
            PH_RAMP_UP: begin
               if (level_ff == LevelTop) begin
                  if (in_alert_ff) begin
                     count_in = WaitTicks;
                     phase_in = PH_LV_WAIT;
                  end else begin
                     count_in = high_hold_ff;
                     phase_in = PH_HOLD_HIGH;
                  end
               end else begin
                  level_in     = level_ff + 1'b1;
                  load_current = 1'b1;
               end
            end
            PH_HOLD_HIGH: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  phase_in = PH_RAMP_DOWN;
               end
            end
            PH_LV_WAIT: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  forced_off = 1'b1;
                  count_in   = OffTicks;
                  phase_in   = PH_FORCED_OFF;
               end
            end
            PH_FORCED_OFF: begin
               forced_off = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  phase_in = PH_RAMP_DOWN;
               end
            end
            PH_RAMP_DOWN: begin
               if (level_ff == '0) begin
                  count_in = low_hold_ff;
                  phase_in = PH_HOLD_LOW;
               end else begin
                  level_in     = level_ff - 1'b1;
                  load_current = 1'b1;
               end
            end
            PH_HOLD_LOW: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  phase_in = PH_RAMP_UP;
               end
            end
            default: begin
               phase_in = PH_RAMP_UP;
            end
         endcase
      end
   end

   always_comb begin
      if (in_command_ff == CMD_RESTART) begin
         current_in = '0;
         led_in     = 1'b1;
      end else begin
         current_in = load_current ? level_current : current_ff;
         led_in     = !((current_in < min_on_ff) || forced_off);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_RAMP_UP;
         level_ff   <= '0;
         count_ff   <= '0;
         current_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         count_ff   <= count_in;
         current_ff <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_current_ff <= current_in;
         rsp_led_ff     <= led_in;
         rsp_phase_ff   <= phase_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_current_ma = rsp_current_ff;
   assign rsp_led_on           = rsp_led_ff;
   assign rsp_phase            = rsp_phase_ff;

   assign top_phase      = (phase_ff == PH_HOLD_HIGH) || (phase_ff == PH_LV_WAIT) ||
                           (phase_ff == PH_FORCED_OFF);
   assign rsp_forced_off = rsp_valid_ff && (rsp_phase_ff == PH_FORCED_OFF);
   assign state_vec      = {phase_ff, level_ff, count_ff, current_ff};

   `LBS_ASSERT(a_level_in_range, clock, reset, level_ff <= LevelTop, "level beyond top")
   `LBS_ASSERT(a_top_phases_at_top, clock, reset, top_phase |-> level_ff == LevelTop, "not at top")
   `LBS_ASSERT(a_forced_off_dark, clock, reset, rsp_forced_off |-> !rsp_led_ff, "led on when off")
   `LBS_ASSERT(a_state_holds, clock, reset, !fire |=> $stable(state_vec), "state moved while idle")

endmodule
